// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	// queue geometry and field widths
	localparam int QUEUE_DEPTH    = 16;
	localparam int VALUE_WIDTH    = 32;
	localparam int PRIORITY_WIDTH = 8;
	localparam int ADDR_W         = $clog2(QUEUE_DEPTH);
	localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
	localparam int STATUS_W       = 2;

	// operation codes
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// one stored entry
	typedef struct packed {
		logic [PRIORITY_WIDTH-1:0] prio;
		logic [VALUE_WIDTH-1:0]    value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// request from the controller to the entry memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// one result item
	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic [VALUE_WIDTH-1:0]    value;
		logic [PRIORITY_WIDTH-1:0] prio;
		logic                      empty;
		logic [CNT_W-1:0]          count;
	} result_t;

endpackage

// File: hw/rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface spq_in_if;
	import spq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [VALUE_WIDTH-1:0]    item_value;
	logic [PRIORITY_WIDTH-1:0] item_priority;

	modport source (output valid, func, item_value, item_priority, input ready);
	modport sink   (input valid, func, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
	import spq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic [VALUE_WIDTH-1:0]    out_value;
	logic [PRIORITY_WIDTH-1:0] out_priority;
	logic                      now_empty;
	logic [CNT_W-1:0]          entry_count;

	modport source (output valid, status, out_value, out_priority, now_empty, entry_count,
		input ready);
	modport sink   (input valid, status, out_value, out_priority, now_empty, entry_count,
		output ready);
endinterface

// File: hw/rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for the sorted queue: circular buffer kept in priority order,
// insertion by shifting entries up from the tail, one entry per cycle.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	spq_in_if.sink            req,
	spq_out_if.source         rsp,
	output spq_pkg::mem_req_t mem_req,
	input  spq_pkg::entry_t   rd_entry
);
	import spq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ,
		S_PUT,
		S_DEQ,
		S_RESP
	} state_t;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	entry_t            new_q;
	result_t           res_q;
	result_t           out_q;
	logic              out_valid_q;

	logic    acc;
	logic    out_free;
	logic    full;
	logic    fin_valid;
	result_t fin_res;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] pos_m1;
	logic [CNT_W-1:0] pos_m2;
	entry_t  req_entry;

	// circular address: base plus logical offset, wrapped at the depth
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
		input logic [ADDR_W-1:0] off);
		logic [ADDR_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
			s = s - (ADDR_W+1)'(QUEUE_DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

	// handshake
	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign cnt_m1    = count_q - CNT_W'(1);
	assign pos_m1    = pos_q - CNT_W'(1);
	assign pos_m2    = pos_q - CNT_W'(2);
	assign req_entry = '{prio: req.item_priority, value: req.item_value};

	// next state, memory requests and finished result
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		pos_d     = pos_q;
		mem_req   = '0;
		fin_valid = 1'b0;
		fin_res   = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (req.func == FUNC_DEQ) begin
						if (count_q == '0) begin
							fin_valid      = 1'b1;
							fin_res.status = ST_EMPTY;
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = head_q;
							state_d       = S_DEQ;
						end
					end else if (full) begin
						fin_valid      = 1'b1;
						fin_res.status = ST_FULL;
					end else if (count_q == '0) begin
						// first entry goes straight to the front
						mem_req.we    = 1'b1;
						mem_req.waddr = head_q;
						mem_req.wdata = req_entry;
						count_d       = count_q + CNT_W'(1);
						fin_valid     = 1'b1;
						fin_res.status = ST_DONE;
					end else begin
						// start the scan at the tail entry
						mem_req.re    = 1'b1;
						mem_req.raddr = wrap_add(head_q, cnt_m1[ADDR_W-1:0]);
						pos_d         = count_q;
						state_d       = S_ENQ;
					end
				end
			end
			S_ENQ: begin
				if (rd_entry.prio < new_q.prio) begin
					// lower priority entry moves one slot back
					mem_req.we    = 1'b1;
					mem_req.waddr = wrap_add(head_q, pos_q[ADDR_W-1:0]);
					mem_req.wdata = rd_entry;
					pos_d         = pos_m1;
					if (pos_q == CNT_W'(1)) begin
						state_d = S_PUT;
					end else begin
						mem_req.re    = 1'b1;
						mem_req.raddr = wrap_add(head_q, pos_m2[ADDR_W-1:0]);
					end
				end else begin
					mem_req.we     = 1'b1;
					mem_req.waddr  = wrap_add(head_q, pos_q[ADDR_W-1:0]);
					mem_req.wdata  = new_q;
					count_d        = count_q + CNT_W'(1);
					fin_valid      = 1'b1;
					fin_res.status = ST_DONE;
				end
			end
			S_PUT: begin
				// new entry takes the front slot
				mem_req.we     = 1'b1;
				mem_req.waddr  = head_q;
				mem_req.wdata  = new_q;
				count_d        = count_q + CNT_W'(1);
				fin_valid      = 1'b1;
				fin_res.status = ST_DONE;
			end
			S_DEQ: begin
				head_d         = wrap_add(head_q, ADDR_W'(1));
				count_d        = cnt_m1;
				fin_valid      = 1'b1;
				fin_res.status = ST_DONE;
				fin_res.value  = rd_entry.value;
				fin_res.prio   = rd_entry.prio;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		fin_res.count = count_d;
		fin_res.empty = (count_d == '0);
		if (fin_valid) begin
			state_d = out_free ? S_IDLE : S_RESP;
		end
	end

	// control state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if ((fin_valid || state_q == S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		if (acc) begin
			new_q <= req_entry;
		end
		if (fin_valid) begin
			if (out_free) begin
				out_q <= fin_res;
			end else begin
				res_q <= fin_res;
			end
		end else if (state_q == S_RESP && out_free) begin
			out_q <= res_q;
		end
	end

	// result port
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.out_value    = out_q.value;
	assign rsp.out_priority = out_q.prio;
	assign rsp.now_empty    = out_q.empty;
	assign rsp.entry_count  = out_q.count;
endmodule

// File: hw/rtl/sorted_priority_queue_unit.sv
// Dequeue: head entry read from the RAM, then registered as the result; no new item is taken before.
// Enqueue: entries of lower priority move back one slot,
//   one entry per cycle through the single read and write port of the entry RAM.
// Dequeue on empty, enqueue on full, enqueue into empty queue: finished in the idle state, no RAM read.
// Reset clears head pointer and count; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue held in one RAM in priority order, highest first.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
	input  logic      clk,
	input  logic      arst_n,
	spq_in_if.sink    req,
	spq_out_if.source rsp
);
	import spq_pkg::*;

	mem_req_t           mem_req;
	logic [ENTRY_W-1:0] rdata;
	entry_t             rd_entry;

	assign rd_entry = entry_t'(rdata);

	// entry storage
	spq_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// sequencer
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.mem_req  (mem_req),
		.rd_entry (rd_entry)
	);
endmodule
